// ===== hdl/ctl_pkg.sv =====
// Shared types, codes and constants for the compact trie lookup block.
// Used by ctl_ctrl, ctl_dp and compact_trie_lookup_top; depends on nothing.
package ctl_pkg;

	// Default sizes
	localparam int MAX_NODES_DEF  = 4096;
	localparam int MAX_LEVELS_DEF = 32;
	localparam int ALPHABET_DEF   = 26;

	// Field widths
	localparam int CMD_W      = 2;
	localparam int LETTER_W   = 8;
	localparam int IDX_W      = 12;
	localparam int MASK_W     = 26;
	localparam int PREC_W     = 12;
	localparam int ROW_W      = 12;
	localparam int COUNT_W    = 13;
	localparam int ROWC_W     = 6;
	localparam int MATCHED_W  = 6;
	localparam int PCNT_W     = 5;
	localparam int NEXT_W     = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_QUERY     = 2'd0,
		CMD_EMPTY     = 2'd1,
		CMD_LOAD_NODE = 2'd2,
		CMD_LOAD_ROW  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_STEP,
		ST_RDNODE,
		ST_REPORT
	} state_t;

	// One node table entry
	typedef struct packed {
		logic              end_flag;
		logic [PREC_W-1:0] prec;
		logic [MASK_W-1:0] mask;
	} node_entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic restart;
		logic latch;
		logic load_node;
		logic load_row;
		logic eval;
		logic step;
		logic report;
	} ctl_cmd_t;

	// Mask bits that belong to the alphabet
	function automatic logic [MASK_W-1:0] alpha_mask(input int alphabet);
		logic [MASK_W-1:0] m;
		for (int i = 0; i < MASK_W; i++) begin
			m[i] = (i < alphabet);
		end
		return m;
	endfunction

	// Population count: per-nibble counts, then a short sum
	function automatic logic [PCNT_W-1:0] popcount26(input logic [MASK_W-1:0] v);
		logic [2:0]        nib [7];
		logic [PCNT_W-1:0] sum;
		for (int g = 0; g < 7; g++) begin
			nib[g] = 3'd0;
			for (int b = 0; b < 4; b++) begin
				if (g * 4 + b < MASK_W) begin
					nib[g] = nib[g] + {2'd0, v[g * 4 + b]};
				end
			end
		end
		sum = '0;
		for (int g = 0; g < 7; g++) begin
			sum = sum + PCNT_W'(nib[g]);
		end
		return sum;
	endfunction

endpackage

// ===== hdl/ctl_ctrl.sv =====
// Controller state machine of the compact trie lookup block.
// Depends on ctl_pkg; drives ctl_dp through a ctl_cmd_t command bundle.
module ctl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ctl_pkg::CMD_W-1:0] command,
	input  logic                 word_start,
	input  logic                 word_end,
	output logic                 busy,
	output logic                 done,
	output ctl_pkg::ctl_cmd_t    cmd
);
	import ctl_pkg::*;

	state_t state_q, state_d;
	logic   end_q;
	logic   done_q;

	// State, word-end flag and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.report;
			if (cmd.latch) begin
				end_q <= word_end;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd_t'(command))
						CMD_QUERY: begin
							cmd.restart = word_start;
							cmd.latch   = 1'b1;
							state_d     = ST_FETCH;
						end
						CMD_EMPTY: begin
							cmd.restart = 1'b1;
							state_d     = ST_REPORT;
						end
						CMD_LOAD_NODE: cmd.load_node = 1'b1;
						CMD_LOAD_ROW:  cmd.load_row  = 1'b1;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FETCH: begin
				cmd.eval = 1'b1;
				state_d  = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = end_q ? ST_RDNODE : ST_IDLE;
			end
			// node read of the reached node is in flight
			ST_RDNODE: state_d = ST_REPORT;
			ST_REPORT: begin
				cmd.report = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ===== hdl/ctl_dp.sv =====
// Datapath of the compact trie lookup block: node and row memories, walk state,
// configuration registers and result registers. Depends on ctl_pkg.
module ctl_dp #(
	parameter int MAX_NODES  = ctl_pkg::MAX_NODES_DEF,
	parameter int MAX_LEVELS = ctl_pkg::MAX_LEVELS_DEF,
	parameter int ALPHABET   = ctl_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctl_pkg::ctl_cmd_t             cmd,
	input  logic [ctl_pkg::LETTER_W-1:0]  letter,
	input  logic [ctl_pkg::IDX_W-1:0]     table_index,
	input  logic [ctl_pkg::MASK_W-1:0]    child_mask,
	input  logic [ctl_pkg::PREC_W-1:0]    preceding_count,
	input  logic                          end_flag,
	input  logic [ctl_pkg::ROW_W-1:0]     level_base,
	input  logic                          cfg_write,
	input  logic [ctl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ctl_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          word_found,
	output logic                          has_further,
	output logic [ctl_pkg::MATCHED_W-1:0] letters_matched
);
	import ctl_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int LVW = $clog2(MAX_LEVELS);
	localparam logic [MASK_W-1:0] AlphaMask = alpha_mask(ALPHABET);

	// Memories
	node_entry_t       node_mem [MAX_NODES];
	logic [ROW_W-1:0]  row_mem  [MAX_LEVELS];
	node_entry_t       node_rd_q;
	logic [ROW_W-1:0]  row_rd_q;

	// Walk state and configuration
	logic [COUNT_W-1:0] cur_node_q;
	logic [LVW-1:0]     cur_level_q;
	logic               match_q;
	logic [COUNT_W-1:0] node_count_q;
	logic [ROWC_W-1:0]  row_count_q;

	// Step operands
	logic [LETTER_W-1:0] letter_q;
	logic [COUNT_W-1:0]  partial_q;
	logic [PCNT_W-1:0]   pcnt_q;
	logic                ok_q;

	// Result payload
	logic                 found_q;
	logic                 further_q;
	logic [MATCHED_W-1:0] matched_q;

	logic [NW-1:0]       node_raddr;
	logic [LVW-1:0]      row_raddr;
	logic [MASK_W-1:0]   amask;
	logic [MASK_W-1:0]   below;
	logic                bit_ok;
	logic                level_ok;
	logic                cur_live;
	logic [NEXT_W-1:0]   next_node;
	logic                next_live;

	// Read at the root when restarting, else at the walk position
	assign node_raddr = cmd.restart ? '0 : NW'(cur_node_q);
	assign row_raddr  = cmd.restart ? LVW'(1) : LVW'(cur_level_q + 1'b1);

	// Node table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_node && (int'(table_index) < MAX_NODES)) begin
			node_mem[NW'(table_index)] <= '{end_flag: end_flag, prec: preceding_count,
				mask: child_mask};
		end
		node_rd_q <= node_mem[node_raddr];
	end

	// Row table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_row && (int'(table_index) < MAX_LEVELS)) begin
			row_mem[LVW'(table_index)] <= level_base;
		end
		row_rd_q <= row_mem[row_raddr];
	end

	// Child test and rank of the letter in the mask
	assign amask  = node_rd_q.mask & AlphaMask;
	assign bit_ok = (int'(letter_q) < MASK_W) && amask[letter_q[PCNT_W-1:0]];
	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			below[i] = amask[i] && (i < int'(letter_q));
		end
	end
	assign level_ok = (int'(cur_level_q) + 1 < int'(row_count_q))
		&& (int'(cur_level_q) + 1 < MAX_LEVELS);
	assign cur_live = (cur_node_q < node_count_q) && (int'(cur_node_q) < MAX_NODES);

	// Final index and its range check
	assign next_node = NEXT_W'(partial_q) + NEXT_W'(pcnt_q);
	assign next_live = (next_node < NEXT_W'(node_count_q)) && (int'(next_node) < MAX_NODES);

	// Operand registers for the step
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			letter_q <= letter;
		end
		if (cmd.eval) begin
			partial_q <= COUNT_W'(row_rd_q) + COUNT_W'(node_rd_q.prec);
			pcnt_q    <= popcount26(below);
			ok_q      <= match_q && cur_live && bit_ok && level_ok;
		end
	end

	// Walk state: restart at the root, advance or drop on a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_node_q  <= '0;
			cur_level_q <= '0;
			match_q     <= 1'b0;
		end else if (cmd.restart) begin
			cur_node_q  <= '0;
			cur_level_q <= '0;
			match_q     <= (node_count_q != '0);
		end else if (cmd.step) begin
			match_q <= ok_q && next_live;
			if (ok_q && next_live) begin
				cur_node_q  <= COUNT_W'(next_node);
				cur_level_q <= LVW'(cur_level_q + 1'b1);
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			row_count_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data;
				CFG_ROW_COUNT:  row_count_q  <= cfg_data[ROWC_W-1:0];
				default: ;
			endcase
		end
	end

	// Result registers, loaded when the reached node has been read
	always_ff @(posedge clk) begin
		if (cmd.report) begin
			found_q   <= match_q && cur_live && node_rd_q.end_flag;
			further_q <= match_q && cur_live && (amask != '0);
			matched_q <= (int'(cur_level_q) > 63) ? MATCHED_W'(63) : MATCHED_W'(cur_level_q);
		end
	end

	assign word_found      = found_q;
	assign has_further     = further_q;
	assign letters_matched = matched_q;

endmodule

// ===== hdl/compact_trie_lookup_top.sv =====
// Top level of the compact trie lookup block: controller plus datapath.
// Depends on ctl_pkg, ctl_ctrl and ctl_dp.
//
// An item is taken when start is high and busy is low. Loads give no result.
// An empty-word query goes straight to its report; a letter passes through the
// node and row-start read, the rank and partial sum, and the final add and range
// check, and a letter that ends a word then has the reached node read again to
// report on it. The result shows for one cycle with done, in the first cycle
// with busy low; it cannot be held off, so sample it then.
// Configuration writes are always ready and are meant for idle periods.
module compact_trie_lookup_top #(
	parameter int MAX_NODES  = ctl_pkg::MAX_NODES_DEF,
	parameter int MAX_LEVELS = ctl_pkg::MAX_LEVELS_DEF,
	parameter int ALPHABET   = ctl_pkg::ALPHABET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ctl_pkg::CMD_W-1:0]      command,
	input  logic [ctl_pkg::LETTER_W-1:0]   letter,
	input  logic                           word_start,
	input  logic                           word_end,
	input  logic [ctl_pkg::IDX_W-1:0]      table_index,
	input  logic [ctl_pkg::MASK_W-1:0]     child_mask,
	input  logic [ctl_pkg::PREC_W-1:0]     preceding_count,
	input  logic                           end_flag,
	input  logic [ctl_pkg::ROW_W-1:0]      level_base,
	output logic                           done,
	output logic                           word_found,
	output logic                           has_further,
	output logic [ctl_pkg::MATCHED_W-1:0]  letters_matched,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ctl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ctl_pkg::*;

	ctl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	ctl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.command    (command),
		.word_start (word_start),
		.word_end   (word_end),
		.busy       (busy),
		.done       (done),
		.cmd        (cmd)
	);

	ctl_dp #(
		.MAX_NODES  (MAX_NODES),
		.MAX_LEVELS (MAX_LEVELS),
		.ALPHABET   (ALPHABET)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.letter          (letter),
		.table_index     (table_index),
		.child_mask      (child_mask),
		.preceding_count (preceding_count),
		.end_flag        (end_flag),
		.level_base      (level_base),
		.cfg_write       (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.word_found      (word_found),
		.has_further     (has_further),
		.letters_matched (letters_matched)
	);

endmodule
